// ===== rtl/artt_pkg.sv =====
// Shared types and codes for the address region translation table.
package artt_pkg;

	// Operation carried by one item.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Status reported with each result.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// Control part of the token that walks down the chain of cells.
	typedef struct packed {
		logic valid;
		logic found;
	} tok_ctl_t;

	localparam int unsigned DEV_BITS = 4;
	localparam int unsigned OFF_BITS = 64;

endpackage

// ===== rtl/artt_cell.sv =====
// One table entry of the translation chain, with its slot of the walking token.
module artt_cell #(
	parameter int unsigned INDEX        = 0,
	parameter int unsigned ADDRESS_BITS = 48,
	parameter int unsigned COUNT_BITS   = 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item held steady by the top level while the token walks.
	input  artt_pkg::op_t                       op,
	input  logic [ADDRESS_BITS-1:0]             address,
	input  logic [ADDRESS_BITS-1:0]             region_size,
	input  logic [artt_pkg::DEV_BITS-1:0]       device_index,
	input  logic [artt_pkg::OFF_BITS-1:0]       device_offset,
	input  logic [COUNT_BITS-1:0]               count,
	// Token from the previous cell.
	input  artt_pkg::tok_ctl_t                  tok_in,
	input  logic [artt_pkg::DEV_BITS-1:0]       tok_in_dev,
	input  logic [artt_pkg::OFF_BITS-1:0]       tok_in_off,
	// Token to the next cell.
	output artt_pkg::tok_ctl_t                  tok_out,
	output logic [artt_pkg::DEV_BITS-1:0]       tok_out_dev,
	output logic [artt_pkg::OFF_BITS-1:0]       tok_out_off,
	// Stored entry of the next cell, pulled in when a remove closes the gap.
	input  logic [ADDRESS_BITS-1:0]             nxt_start,
	input  logic [ADDRESS_BITS:0]               nxt_end,
	input  logic [artt_pkg::DEV_BITS-1:0]       nxt_dev,
	input  logic [artt_pkg::OFF_BITS-1:0]       nxt_base,
	// Stored entry of this cell.
	output logic [ADDRESS_BITS-1:0]             ent_start,
	output logic [ADDRESS_BITS:0]               ent_end,
	output logic [artt_pkg::DEV_BITS-1:0]       ent_dev,
	output logic [artt_pkg::OFF_BITS-1:0]       ent_base
);

	localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(INDEX);
	localparam bit                    SAT = (ADDRESS_BITS >= 64);

	logic [ADDRESS_BITS-1:0]         start_q;
	logic [ADDRESS_BITS:0]           end_q;
	logic [artt_pkg::DEV_BITS-1:0]   dev_q;
	logic [artt_pkg::OFF_BITS-1:0]   base_q;

	artt_pkg::tok_ctl_t              tok_q;
	logic [artt_pkg::DEV_BITS-1:0]   tok_dev_q;
	logic [artt_pkg::OFF_BITS-1:0]   tok_off_q;

	logic                            in_use;
	logic                            hit;
	logic                            start_eq;
	logic [ADDRESS_BITS:0]           end_sum;
	logic [ADDRESS_BITS:0]           end_new;
	logic [artt_pkg::OFF_BITS-1:0]   addr_ext;

	assign in_use   = (count > IDX);
	assign start_eq = in_use && (start_q == address);
	assign hit      = in_use && (start_q <= address) && ({1'b0, address} < end_q);
	assign addr_ext = artt_pkg::OFF_BITS'(address);
	assign end_sum  = {1'b0, address} + {1'b0, region_size};

	// A region end that overflows a full 64-bit address space sticks at all ones.
	always_comb begin
		end_new = end_sum;
		if (SAT && end_sum[ADDRESS_BITS]) begin
			end_new = {1'b0, {ADDRESS_BITS{1'b1}}};
		end
	end

	// Entry storage; the translation base is kept as offset minus start.
	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			if (op == artt_pkg::OP_INSERT && count == IDX) begin
				start_q <= address;
				end_q   <= end_new;
				dev_q   <= device_index;
				base_q  <= device_offset - addr_ext;
			end else if (op == artt_pkg::OP_REMOVE && (tok_in.found || start_eq)) begin
				start_q <= nxt_start;
				end_q   <= nxt_end;
				dev_q   <= nxt_dev;
				base_q  <= nxt_base;
			end
		end
	end

	// Token slot: control is reset, the carried result is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found;
			if (tok_in.valid && !tok_in.found) begin
				if ((op == artt_pkg::OP_LOOKUP && hit) ||
				    (op == artt_pkg::OP_REMOVE && start_eq)) begin
					tok_q.found <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_dev_q <= tok_in_dev;
		tok_off_q <= tok_in_off;
		if (tok_in.valid && !tok_in.found && op == artt_pkg::OP_LOOKUP && hit) begin
			tok_dev_q <= dev_q;
			tok_off_q <= base_q + addr_ext;
		end
	end

	assign tok_out     = tok_q;
	assign tok_out_dev = tok_dev_q;
	assign tok_out_off = tok_off_q;
	assign ent_start   = start_q;
	assign ent_end     = end_q;
	assign ent_dev     = dev_q;
	assign ent_base    = base_q;

endmodule

// ===== rtl/address_region_translation_table.sv =====
// Top level of the address region translation table: control, counter and cell chain.
//
// The table holds up to TABLE_DEPTH address regions in a row of identical cells,
// one region per cell, in table order. An item is taken when start is high and
// busy is low; mode selects insert, remove by start address, or lookup. The item
// then travels as a token down the row, one cell per clock: a launch register
// sends it into the first cell, it passes through every cell in turn, and a final
// register holds the answer. busy stays high for the whole walk, and the result
// appears for exactly one cycle with done high; there is no way to hold it back,
// so the receiver must take it in that cycle. busy falls in the same cycle that
// done rises, so a new item may be started while the previous result is on the
// ports. Stored entries are not cleared at reset; only entries below the region
// count are ever consulted.
module address_region_translation_table #(
	parameter int unsigned TABLE_DEPTH  = 256,
	parameter int unsigned ADDRESS_BITS = 48
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [1:0]                                 mode,
	input  logic [ADDRESS_BITS-1:0]                    address,
	input  logic [ADDRESS_BITS-1:0]                    region_size,
	input  logic [artt_pkg::DEV_BITS-1:0]              device_index,
	input  logic [artt_pkg::OFF_BITS-1:0]              device_offset,
	output logic                                       busy,
	output logic                                       done,
	output logic [1:0]                                 status,
	output logic [artt_pkg::DEV_BITS-1:0]              hit_index,
	output logic [artt_pkg::OFF_BITS-1:0]              translated_offset,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]           entry_count
);

	localparam int unsigned            CW   = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0]          FULL = CW'(TABLE_DEPTH);

	// The accepted item is held here for the whole walk and broadcast to all cells.
	artt_pkg::op_t                     op_q;
	logic [ADDRESS_BITS-1:0]           addr_q;
	logic [ADDRESS_BITS-1:0]           size_q;
	logic [artt_pkg::DEV_BITS-1:0]     dev_q;
	logic [artt_pkg::OFF_BITS-1:0]     off_q;

	logic                              busy_q;
	logic                              launch_q;
	logic                              done_q;
	logic [CW-1:0]                     count_q;

	logic [1:0]                        status_q;
	logic [artt_pkg::DEV_BITS-1:0]     hit_q;
	logic [artt_pkg::OFF_BITS-1:0]     xlat_q;

	logic                              accept;

	// Token and entry links along the row; the last entry link is a dummy neighbor.
	artt_pkg::tok_ctl_t                tok_ctl [0:TABLE_DEPTH];
	logic [artt_pkg::DEV_BITS-1:0]     tok_dev [0:TABLE_DEPTH];
	logic [artt_pkg::OFF_BITS-1:0]     tok_off [0:TABLE_DEPTH];
	logic [ADDRESS_BITS-1:0]           e_start [0:TABLE_DEPTH];
	logic [ADDRESS_BITS:0]             e_end   [0:TABLE_DEPTH];
	logic [artt_pkg::DEV_BITS-1:0]     e_dev   [0:TABLE_DEPTH];
	logic [artt_pkg::OFF_BITS-1:0]     e_base  [0:TABLE_DEPTH];

	artt_pkg::tok_ctl_t                tok_last;
	logic                              finish;

	assign accept = start && !busy_q;

	// The token enters the first cell with nothing found and an empty result.
	assign tok_ctl[0] = '{valid: launch_q, found: 1'b0};
	assign tok_dev[0] = '0;
	assign tok_off[0] = '0;

	// Past the last cell a remove shifts in don't-care data.
	assign e_start[TABLE_DEPTH] = '0;
	assign e_end[TABLE_DEPTH]   = '0;
	assign e_dev[TABLE_DEPTH]   = '0;
	assign e_base[TABLE_DEPTH]  = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		artt_cell #(
			.INDEX        (i),
			.ADDRESS_BITS (ADDRESS_BITS),
			.COUNT_BITS   (CW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.op            (op_q),
			.address       (addr_q),
			.region_size   (size_q),
			.device_index  (dev_q),
			.device_offset (off_q),
			.count         (count_q),
			.tok_in        (tok_ctl[i]),
			.tok_in_dev    (tok_dev[i]),
			.tok_in_off    (tok_off[i]),
			.tok_out       (tok_ctl[i+1]),
			.tok_out_dev   (tok_dev[i+1]),
			.tok_out_off   (tok_off[i+1]),
			.nxt_start     (e_start[i+1]),
			.nxt_end       (e_end[i+1]),
			.nxt_dev       (e_dev[i+1]),
			.nxt_base      (e_base[i+1]),
			.ent_start     (e_start[i]),
			.ent_end       (e_end[i]),
			.ent_dev       (e_dev[i]),
			.ent_base      (e_base[i])
		);
	end

	assign tok_last = tok_ctl[TABLE_DEPTH];
	assign finish   = tok_last.valid;

	// Capture the item at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= artt_pkg::op_t'(mode);
			addr_q <= address;
			size_q <= region_size;
			dev_q  <= device_index;
			off_q  <= device_offset;
		end
	end

	// Control: busy covers the launch and the full walk, the counter moves at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			launch_q <= accept;
			done_q   <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				if (op_q == artt_pkg::OP_INSERT && count_q != FULL) begin
					count_q <= count_q + CW'(1);
				end else if (op_q == artt_pkg::OP_REMOVE && tok_last.found) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Result payload, formed from the token as it leaves the last cell.
	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= artt_pkg::ST_OK;
			hit_q    <= '0;
			xlat_q   <= '0;
			case (op_q)
				artt_pkg::OP_INSERT: begin
					if (count_q == FULL) begin
						status_q <= artt_pkg::ST_FULL;
					end
				end
				artt_pkg::OP_REMOVE: begin
					if (!tok_last.found) begin
						status_q <= artt_pkg::ST_MISS;
					end
				end
				artt_pkg::OP_LOOKUP: begin
					if (tok_last.found) begin
						hit_q  <= tok_dev[TABLE_DEPTH];
						xlat_q <= tok_off[TABLE_DEPTH];
					end else begin
						status_q <= artt_pkg::ST_MISS;
						xlat_q   <= '1;
					end
				end
				default: begin
					status_q <= artt_pkg::ST_OK;
				end
			endcase
		end
	end

	assign busy              = busy_q;
	assign done              = done_q;
	assign status            = status_q;
	assign hit_index         = hit_q;
	assign translated_offset = xlat_q;
	assign entry_count       = count_q;

endmodule

// ===== verif/artt_answer_compare.sv =====
// Predicts each answer of the translation table and compares it with what the block returns.
`timescale 1ns / 100ps

module artt_answer_compare #(
	parameter int unsigned TABLE_DEPTH  = 256,
	parameter int unsigned ADDRESS_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [1:0]                        mode,
	input  logic [ADDRESS_BITS-1:0]           address,
	input  logic [ADDRESS_BITS-1:0]           region_size,
	input  logic [artt_pkg::DEV_BITS-1:0]     device_index,
	input  logic [artt_pkg::OFF_BITS-1:0]     device_offset,
	input  logic                              done,
	input  logic [1:0]                        status,
	input  logic [artt_pkg::DEV_BITS-1:0]     hit_index,
	input  logic [artt_pkg::OFF_BITS-1:0]     translated_offset,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]  entry_count,
	output int unsigned                       mismatch_count,
	output int unsigned                       answers_pending
);
	import artt_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		status_t               st;
		logic [DEV_BITS-1:0]   dev;
		logic [OFF_BITS-1:0]   off;
		logic [CNT_BITS-1:0]   cnt;
	} answer_t;

	// Own copy of the region table, kept in table order.
	logic [ADDRESS_BITS-1:0] base_tbl  [TABLE_DEPTH];
	logic [ADDRESS_BITS:0]   limit_tbl [TABLE_DEPTH];
	logic [DEV_BITS-1:0]     owner_tbl [TABLE_DEPTH];
	logic [OFF_BITS-1:0]     devoff_tbl[TABLE_DEPTH];
	int unsigned             region_total;

	answer_t answers_due[$];

	function automatic answer_t translate_item(op_t op, logic [ADDRESS_BITS-1:0] addr,
			logic [ADDRESS_BITS-1:0] size, logic [DEV_BITS-1:0] dev,
			logic [OFF_BITS-1:0] off);
		answer_t                 a;
		int                      idx;
		int                      j;
		logic [ADDRESS_BITS-1:0] delta;
		logic [ADDRESS_BITS:0]   reach;
		a.st  = ST_OK;
		a.dev = '0;
		a.off = '0;
		idx   = -1;
		case (op)
			OP_INSERT: begin
				if (region_total >= TABLE_DEPTH) begin
					a.st = ST_FULL;
				end else begin
					// The end is one bit wider than the start, so it never wraps.
					// Past a full 64-bit address space it sticks at all ones.
					reach = {1'b0, addr} + {1'b0, size};
					if (ADDRESS_BITS >= 64 && reach[ADDRESS_BITS])
						reach = {1'b0, {ADDRESS_BITS{1'b1}}};
					base_tbl[region_total]   = addr;
					limit_tbl[region_total]  = reach;
					owner_tbl[region_total]  = dev;
					devoff_tbl[region_total] = off;
					region_total++;
				end
			end
			OP_REMOVE: begin
				for (j = 0; j < int'(region_total); j++)
					if (idx < 0 && base_tbl[j] == addr)
						idx = j;
				if (idx < 0) begin
					a.st = ST_MISS;
				end else begin
					for (j = idx; j + 1 < int'(region_total); j++) begin
						base_tbl[j]   = base_tbl[j+1];
						limit_tbl[j]  = limit_tbl[j+1];
						owner_tbl[j]  = owner_tbl[j+1];
						devoff_tbl[j] = devoff_tbl[j+1];
					end
					region_total--;
				end
			end
			OP_LOOKUP: begin
				for (j = 0; j < int'(region_total); j++)
					if (idx < 0 && addr >= base_tbl[j] && {1'b0, addr} < limit_tbl[j])
						idx = j;
				if (idx < 0) begin
					a.st  = ST_MISS;
					a.off = '1;
				end else begin
					delta = addr - base_tbl[idx];
					a.dev = owner_tbl[idx];
					a.off = devoff_tbl[idx] + OFF_BITS'(delta);
				end
			end
			default: ;
		endcase
		a.cnt = CNT_BITS'(region_total);
		return a;
	endfunction

	initial begin
		mismatch_count  = 0;
		answers_pending = 0;
		region_total    = 0;
	end

	always @(posedge clk) begin
		answer_t want;
		if (!arst_n) begin
			region_total = 0;
			answers_due.delete();
		end else begin
			// The result of the previous item may share this edge with the next acceptance.
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result with no item waiting: status %0d entry_count %0d",
						status, entry_count);
					mismatch_count++;
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						mismatch_count++;
					end
					if (hit_index !== want.dev) begin
						$error("hit_index: expected %0d, actual %0d", want.dev, hit_index);
						mismatch_count++;
					end
					if (translated_offset !== want.off) begin
						$error("translated_offset: expected %h, actual %h",
							want.off, translated_offset);
						mismatch_count++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, actual %0d", want.cnt, entry_count);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				answers_due.push_back(translate_item(op_t'(mode), address, region_size,
					device_index, device_offset));
		end
		answers_pending = answers_due.size();
	end

endmodule

// ===== verif/tb_address_region_translation_table.sv =====
// Stimulus, clock, reset and verdict for the address region translation table.
`timescale 1ns / 100ps

module tb_address_region_translation_table;
	import artt_pkg::*;

	localparam int unsigned TABLE_DEPTH  = 256;
	localparam int unsigned ADDRESS_BITS = 48;
	// The launch register, the register in each cell and the register that holds the answer.
	localparam int unsigned LATENCY      = TABLE_DEPTH + 2;
	// The slowest legal run is a few hundred items, each one full walk long,
	// so this limit leaves several times the margin it needs.
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	localparam logic [ADDRESS_BITS-1:0] ADDR_ONES = '1;
	localparam logic [OFF_BITS-1:0]     OFF_ONES  = '1;

	logic                              clk           = 1'b0;
	logic                              arst_n        = 1'b0;
	logic                              start         = 1'b0;
	logic [1:0]                        mode          = '0;
	logic [ADDRESS_BITS-1:0]           address       = '0;
	logic [ADDRESS_BITS-1:0]           region_size   = '0;
	logic [DEV_BITS-1:0]               device_index  = '0;
	logic [OFF_BITS-1:0]               device_offset = '0;
	logic                              busy;
	logic                              done;
	logic [1:0]                        status;
	logic [DEV_BITS-1:0]               hit_index;
	logic [OFF_BITS-1:0]               translated_offset;
	logic [$clog2(TABLE_DEPTH+1)-1:0]  entry_count;

	int unsigned mismatch_count;
	int unsigned answers_pending;

	// Percentage of cycles in which the sender holds start low.
	int unsigned idle_pct = 26;
	int unsigned cycle_count = 0;

	// Shadow of the regions the table should hold, used to aim removes and lookups
	// at live regions so that most of them hit, to fill the table and to track its peak.
	logic [ADDRESS_BITS-1:0] live_base[$];
	logic [ADDRESS_BITS-1:0] live_span[$];
	int unsigned             peak_regions = 0;
	int unsigned             op_seen[4] = '{default: 0};

	address_region_translation_table #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.mode              (mode),
		.address           (address),
		.region_size       (region_size),
		.device_index      (device_index),
		.device_offset     (device_offset),
		.busy              (busy),
		.done              (done),
		.status            (status),
		.hit_index         (hit_index),
		.translated_offset (translated_offset),
		.entry_count       (entry_count)
	);

	artt_answer_compare #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_answers (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.mode              (mode),
		.address           (address),
		.region_size       (region_size),
		.device_index      (device_index),
		.device_offset     (device_offset),
		.done              (done),
		.status            (status),
		.hit_index         (hit_index),
		.translated_offset (translated_offset),
		.entry_count       (entry_count),
		.mismatch_count    (mismatch_count),
		.answers_pending   (answers_pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [ADDRESS_BITS-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[ADDRESS_BITS-1:0];
	endfunction

	function automatic logic [OFF_BITS-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Region starts come partly from a small pool so that duplicate starts
	// show up often, and partly from the two ends of the address space.
	function automatic logic [ADDRESS_BITS-1:0] pick_start();
		case ($urandom_range(9))
			0:       return '0;
			1:       return ADDR_ONES;
			2, 3:    return ADDRESS_BITS'(48'h1000 * $urandom_range(1, 8));
			default: return rand48();
		endcase
	endfunction

	// Presents one item and holds it until the block takes it. The task is
	// entered and left at a falling edge, and start is written once per falling
	// edge, so an item that follows at once keeps start high without a glitch.
	task automatic issue(op_t op, logic [ADDRESS_BITS-1:0] addr,
			logic [ADDRESS_BITS-1:0] size, logic [DEV_BITS-1:0] dev,
			logic [OFF_BITS-1:0] off);
		logic taken;
		int   k;
		mode          <= op;
		address       <= addr;
		region_size   <= size;
		device_index  <= dev;
		device_offset <= off;
		do begin
			// Idle cycles land anywhere in the walk, not only after busy falls.
			start <= ($urandom_range(99) >= idle_pct);
			@(posedge clk);
			taken = start && !busy;
			@(negedge clk);
		end while (!taken);
		op_seen[op]++;
		if (op == OP_INSERT && live_base.size() < TABLE_DEPTH) begin
			live_base.push_back(addr);
			live_span.push_back(size);
		end else if (op == OP_REMOVE) begin
			k = -1;
			foreach (live_base[i])
				if (k < 0 && live_base[i] == addr)
					k = i;
			if (k >= 0) begin
				live_base.delete(k);
				live_span.delete(k);
			end
		end
		if (live_base.size() > peak_regions)
			peak_regions = live_base.size();
	endtask

	// Lowers start and waits until every answer that is due has come back.
	task automatic wait_for_answers();
		start <= 1'b0;
		@(negedge clk);
		while (answers_pending != 0)
			@(negedge clk);
	endtask

	// Sizes are mostly small, with empty, huge and maximal regions mixed in.
	// Offsets include zero, all ones and values just below the wrap point.
	task automatic random_insert();
		logic [ADDRESS_BITS-1:0] size;
		logic [OFF_BITS-1:0]     off;
		case ($urandom_range(19))
			0, 1:    size = '0;
			2:       size = ADDR_ONES;
			3, 4:    size = rand48();
			default: size = ADDRESS_BITS'($urandom_range(1, 65536));
		endcase
		case ($urandom_range(7))
			0:       off = '0;
			1:       off = OFF_ONES;
			2:       off = OFF_ONES - OFF_BITS'($urandom_range(0, 4096));
			default: off = rand64();
		endcase
		issue(OP_INSERT, pick_start(), size, DEV_BITS'($urandom_range(15)), off);
	endtask

	// Most removes name a live start; the rest usually miss.
	task automatic random_remove();
		logic [ADDRESS_BITS-1:0] addr;
		if (live_base.size() != 0 && $urandom_range(9) < 7)
			addr = live_base[$urandom_range(live_base.size() - 1)];
		else
			addr = pick_start();
		issue(OP_REMOVE, addr, rand48(), DEV_BITS'($urandom_range(15)), rand64());
	endtask

	// Most lookups fall inside a live region, some on its first byte past the
	// end, and the rest anywhere.
	task automatic random_lookup();
		int unsigned             k;
		int unsigned             roll;
		logic [ADDRESS_BITS-1:0] addr;
		roll = $urandom_range(9);
		if (live_base.size() != 0 && roll < 8) begin
			k    = $urandom_range(live_base.size() - 1);
			addr = live_base[k];
			if (roll == 7)
				addr = addr + live_span[k];
			else if (live_span[k] != 0)
				addr = addr + rand48() % live_span[k];
		end else begin
			addr = rand48();
		end
		issue(OP_LOOKUP, addr, rand48(), DEV_BITS'($urandom_range(15)), rand64());
	endtask

	// Weights are percentages; what is left over goes to the unused mode.
	task automatic random_mix(int unsigned n, int unsigned w_ins, int unsigned w_rem,
			int unsigned w_look);
		int unsigned pick;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < w_ins)
				random_insert();
			else if (pick < w_ins + w_rem)
				random_remove();
			else if (pick < w_ins + w_rem + w_look)
				random_lookup();
			else
				issue(OP_NONE, rand48(), rand48(), DEV_BITS'($urandom_range(15)), rand64());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. An empty table answers misses to both lookup and remove,
		// and the unused mode leaves everything alone.
		issue(OP_LOOKUP, '0, '0, '0, '0);
		issue(OP_REMOVE, '0, '0, '0, '0);
		issue(OP_NONE, ADDR_ONES, ADDR_ONES, 4'hf, OFF_ONES);
		// A region at address zero, probed at its first byte, last byte and end.
		issue(OP_INSERT, '0, 48'h10, 4'h0, '0);
		issue(OP_LOOKUP, '0, '0, '0, '0);
		issue(OP_LOOKUP, 48'hf, '0, '0, '0);
		issue(OP_LOOKUP, 48'h10, '0, '0, '0);
		// A region of size zero must never hit.
		issue(OP_INSERT, 48'h100, '0, 4'hf, OFF_ONES);
		issue(OP_LOOKUP, 48'h100, '0, '0, '0);
		// The top of the address space with the largest size: the end needs the extra bit.
		issue(OP_INSERT, ADDR_ONES, ADDR_ONES, 4'hf, OFF_ONES);
		issue(OP_LOOKUP, ADDR_ONES, '0, '0, '0);
		// An offset close to the top, so that the translation wraps.
		issue(OP_INSERT, 48'h1000, 48'h100, 4'h5, 64'hffff_ffff_ffff_fff0);
		issue(OP_LOOKUP, 48'h1020, '0, '0, '0);
		// A second region with the same start: lookup must take the first one.
		issue(OP_INSERT, 48'h1000, 48'h1000, 4'h9, '0);
		issue(OP_LOOKUP, 48'h1050, '0, '0, '0);
		issue(OP_LOOKUP, 48'h1800, '0, '0, '0);
		// Remove takes only the first of the duplicates, then the second, then misses.
		issue(OP_REMOVE, 48'h1000, '0, '0, '0);
		issue(OP_LOOKUP, 48'h1050, '0, '0, '0);
		issue(OP_REMOVE, 48'h1000, '0, '0, '0);
		issue(OP_REMOVE, 48'h1000, '0, '0, '0);
		// Removing from the middle shifts the later region down.
		issue(OP_REMOVE, 48'h100, '0, '0, '0);
		issue(OP_LOOKUP, ADDR_ONES, '0, '0, '0);

		// Mixed traffic with a lightly idling sender.
		random_mix(80, 45, 20, 30);

		// Drain completely, then fill the table to the brim under a heavily idling sender.
		wait_for_answers();
		idle_pct = 68;
		while (live_base.size() < TABLE_DEPTH)
			random_mix(1, 92, 0, 8);
		// Inserts into a full table are refused; a remove that hits opens one slot again.
		repeat (4) random_insert();
		random_lookup();
		random_remove();
		random_insert();
		random_insert();
		issue(OP_REMOVE, 48'h0000_dead_0001, '0, '0, '0);
		random_mix(10, 0, 0, 100);

		// Back-to-back items, draining a good part of the table.
		idle_pct = 0;
		random_mix(60, 10, 45, 40);

		wait_for_answers();
		// Any stray result from the last walk would show up within this window.
		repeat (LATENCY + 4) @(negedge clk);

		$display("Sent %0d inserts, %0d removes, %0d lookups and %0d unused-mode items.",
			op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_LOOKUP], op_seen[OP_NONE]);
		$display("The table held up to %0d regions; %0d field mismatches were seen.",
			peak_regions, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
